// ===== rtl/pl0sm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0sm_pkg
// Shared types, codes and controller/datapath command and status structs for
// the PL/0 p-code stack machine.
// ----------------------------------------------------------------------------
package pl0sm_pkg;

	localparam logic [3:0] OP_LIT = 4'd0;
	localparam logic [3:0] OP_OPR = 4'd1;
	localparam logic [3:0] OP_LOD = 4'd2;
	localparam logic [3:0] OP_STO = 4'd3;
	localparam logic [3:0] OP_CAL = 4'd4;
	localparam logic [3:0] OP_INT = 4'd5;
	localparam logic [3:0] OP_JMP = 4'd6;
	localparam logic [3:0] OP_JPC = 4'd7;
	localparam logic [3:0] OP_RED = 4'd8;
	localparam logic [3:0] OP_WRT = 4'd9;

	localparam logic [10:0] OPR_RET = 11'd0;
	localparam logic [10:0] OPR_NEG = 11'd1;
	localparam logic [10:0] OPR_ADD = 11'd2;
	localparam logic [10:0] OPR_SUB = 11'd3;
	localparam logic [10:0] OPR_MUL = 11'd4;
	localparam logic [10:0] OPR_DIV = 11'd5;
	localparam logic [10:0] OPR_ODD = 11'd6;
	localparam logic [10:0] OPR_EQL = 11'd8;
	localparam logic [10:0] OPR_NEQ = 11'd9;
	localparam logic [10:0] OPR_LSS = 11'd10;
	localparam logic [10:0] OPR_GEQ = 11'd11;
	localparam logic [10:0] OPR_GTR = 11'd12;
	localparam logic [10:0] OPR_LEQ = 11'd13;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DIV0  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [3:0]         operation;
		logic [1:0]         level;
		logic [10:0]        operand;
		logic signed [31:0] read_value;
	} in_item_t;

	typedef struct packed {
		logic [10:0]        next_pc;
		logic               halted;
		logic               out_valid;
		logic signed [31:0] out_value;
		logic [1:0]         status;
	} out_item_t;

	typedef enum logic [2:0] {
		AS_T, AS_T_P1, AS_T_P2, AS_T_P3, AS_BASE, AS_BASE_A
	} addr_sel_t;

	typedef enum logic [1:0] {
		DST_X, DST_Y, DST_BASE
	} dst_t;

	typedef enum logic [2:0] {
		WD_A, WD_X, WD_RES, WD_RV, WD_BASE, WD_B, WD_PC
	} wdata_t;

	typedef enum logic [2:0] {
		T_KEEP, T_INC, T_DEC, T_BDEC, T_REM
	} t_op_t;

	typedef enum logic [1:0] {
		B_KEEP, B_TINC, B_REM
	} b_op_t;

	typedef enum logic [1:0] {
		PC_KEEP, PC_A, PC_X, PC_AIFZ
	} pc_op_t;

	typedef enum logic [1:0] {
		DM_DIV, DM_MODY, DM_MODTA
	} dmode_t;

	typedef struct packed {
		logic      accept;
		logic      clr_en;
		logic      rd_en;
		logic      wr_en;
		addr_sel_t asel;
		dst_t      dst;
		wdata_t    wsel;
		t_op_t     t_op;
		b_op_t     b_op;
		pc_op_t    pc_op;
		logic      walk_init;
		logic      walk_dec;
		logic      div_start;
		dmode_t    dmode;
		logic      alu_en;
		logic      wrt_en;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic       clr_last;
		logic       stopped;
		logic [3:0] op;
		logic       opr_ret;
		logic       opr_unary;
		logic       opr_binary;
		logic       opr_div;
		logic       y_zero;
		logic       lev_zero;
		logic       div_busy;
		logic       out_free;
	} sts_t;

endpackage

// ===== rtl/pl0sm_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0sm_in_if
// Instruction channel: valid/ready handshake with one p-code instruction.
// ----------------------------------------------------------------------------
interface pl0sm_in_if;
	import pl0sm_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pl0sm_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0sm_out_if
// Result channel: valid/ready handshake with one execution result.
// ----------------------------------------------------------------------------
interface pl0sm_out_if;
	import pl0sm_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/pl0_pcode_stack_machine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0_pcode_stack_machine
// PL/0 p-code interpreter core: one instruction in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//  instr  : one request per p-code instruction (operation, level, operand,
//           read_value for red). Taken only when the core is idle.
//  result : one request per instruction: next_pc, halted, wrt value, status.
//  Instruction time depends on the operation and is set by the sequencer
//  and the stack RAM (one write port, one registered read port): divide,
//  unless by zero, runs the divider (one quotient bit a cycle); int and
//  return take a modulo by reciprocal multiply; lod, sto, cal and red
//  follow each static link in turn.
//  The next instruction can be taken in the cycle after the result is loaded.
//  After reset the stack RAM is cleared, one entry a cycle, during which
//  instr.ready stays low.
//  The result sits in an output register; a new instruction is accepted
//  while it waits. If the receiver stalls, the next result holds in the
//  core and no further instruction is taken until the register frees.
//  After halt every instruction returns next_pc 0 with halted set.
// ----------------------------------------------------------------------------
module pl0_pcode_stack_machine #(
	parameter int STACK_DEPTH = 512,
	parameter int MAX_LEVEL   = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	pl0sm_in_if.sink    instr,
	pl0sm_out_if.source result
);
	import pl0sm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pl0sm_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (instr.valid),
		.in_ready (instr.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pl0sm_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_LEVEL   (MAX_LEVEL)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (instr.data),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.out_data  (result.data)
	);
endmodule

// ===== rtl/pl0sm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0sm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pl0sm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/pl0sm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0sm_divider
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pl0sm_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q, quo_q[31]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/pl0sm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0sm_datapath
// Stack memory, machine registers, ALU, divider, modulo unit and result register.
// ----------------------------------------------------------------------------
module pl0sm_datapath #(
	parameter int STACK_DEPTH = 512,
	parameter int MAX_LEVEL   = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pl0sm_pkg::cmd_t      cmd,
	output pl0sm_pkg::sts_t      sts,
	input  pl0sm_pkg::in_item_t  in_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output pl0sm_pkg::out_item_t out_data
);
	import pl0sm_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int LW = $clog2(MAX_LEVEL + 1);
	localparam logic [32:0] DEPTH33 = 33'(STACK_DEPTH);
	localparam logic [AW-1:0] TOP_IDX = AW'(STACK_DEPTH - 1);
	localparam logic [31:0] DEPTH32 = 32'(STACK_DEPTH);
	// floor(2^32 / depth): the remainder estimate is high by at most one depth
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(STACK_DEPTH));

	logic [10:0]   pc_q;
	logic [AW-1:0] b_q;
	logic [AW-1:0] t_q;
	logic          stopped_q;
	logic [3:0]    op_q;
	logic [10:0]   a_q;
	logic [31:0]   rv_q;
	logic [31:0]   x_q;
	logic [31:0]   y_q;
	logic [31:0]   base_q;
	logic [31:0]   res_q;
	logic [LW-1:0] lev_cnt_q;
	logic          rng_err_q;
	logic          div_err_q;
	logic          wv_q;
	logic [AW-1:0] clr_cnt_q;
	logic          rd_pend_q;
	logic          rd_ok_q;
	dst_t          rd_dst_q;
	logic          out_vld_q;
	out_item_t     out_q;
	logic [1:0]    md_cnt_q;
	logic [31:0]   md_src_q;
	logic [63:0]   md_prod_q;
	logic [31:0]   md_est_q;

	logic [32:0]   idx;
	logic          in_range;
	logic [31:0]   wd;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;
	logic [31:0]   rd_val;
	logic [AW-1:0] t_inc;
	logic [AW-1:0] t_dec;
	logic [AW-1:0] b_dec;
	logic [31:0]   ux;
	logic [31:0]   uy;
	logic          dv_start;
	logic          md_start;
	logic          dv_busy;
	logic [31:0]   dv_quo;
	logic [31:0]   md_rem;
	logic [31:0]   alu;
	logic [LW-1:0] lev_eff;
	logic          stopped_n;

	always_comb begin
		case (cmd.asel)
			AS_T:      idx = 33'(t_q);
			AS_T_P1:   idx = 33'(t_q) + 33'd1;
			AS_T_P2:   idx = 33'(t_q) + 33'd2;
			AS_T_P3:   idx = 33'(t_q) + 33'd3;
			AS_BASE:   idx = 33'(base_q);
			AS_BASE_A: idx = 33'(base_q) + 33'(a_q);
			default:   idx = 33'(t_q);
		endcase
	end
	assign in_range = idx < DEPTH33;

	always_comb begin
		case (cmd.wsel)
			WD_A:    wd = 32'(a_q);
			WD_X:    wd = x_q;
			WD_RES:  wd = res_q;
			WD_RV:   wd = rv_q;
			WD_BASE: wd = base_q;
			WD_B:    wd = 32'(b_q);
			WD_PC:   wd = 32'(pc_q);
			default: wd = x_q;
		endcase
	end

	assign ram_we    = cmd.clr_en | (cmd.wr_en & in_range);
	assign ram_waddr = cmd.clr_en ? clr_cnt_q : idx[AW-1:0];
	assign ram_wdata = cmd.clr_en ? '0 : wd;

	pl0sm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (idx[AW-1:0]),
		.rdata (ram_rdata)
	);

	// out-of-range reads return zero
	assign rd_val = rd_ok_q ? ram_rdata : '0;

	assign t_inc = (t_q == TOP_IDX) ? '0 : t_q + AW'(1);
	assign t_dec = (t_q == '0) ? TOP_IDX : t_q - AW'(1);
	assign b_dec = (b_q == '0) ? TOP_IDX : b_q - AW'(1);

	assign ux = x_q[31] ? (32'd0 - x_q) : x_q;
	assign uy = y_q[31] ? (32'd0 - y_q) : y_q;

	assign dv_start = cmd.div_start && (cmd.dmode == DM_DIV);
	assign md_start = cmd.div_start && (cmd.dmode != DM_DIV);

	pl0sm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (ux),
		.divisor  (uy),
		.busy     (dv_busy),
		.quotient (dv_quo)
	);

	// modulo by the stack depth: reciprocal estimate, then one correction
	assign md_rem = (md_est_q >= DEPTH32) ? md_est_q - DEPTH32 : md_est_q;

	always_comb begin
		case (a_q)
			OPR_NEG: alu = 32'd0 - x_q;
			OPR_ODD: alu = {31'd0, x_q[0]};
			OPR_ADD: alu = x_q + y_q;
			OPR_SUB: alu = x_q - y_q;
			OPR_MUL: alu = x_q * y_q;
			OPR_DIV: begin
				if (y_q == '0) begin
					alu = '0;
				end else if (x_q[31] ^ y_q[31]) begin
					alu = 32'd0 - dv_quo;
				end else begin
					alu = dv_quo;
				end
			end
			OPR_EQL: alu = {31'd0, x_q == y_q};
			OPR_NEQ: alu = {31'd0, x_q != y_q};
			OPR_LSS: alu = {31'd0, $signed(x_q) < $signed(y_q)};
			OPR_GEQ: alu = {31'd0, !($signed(x_q) < $signed(y_q))};
			OPR_GTR: alu = {31'd0, $signed(y_q) < $signed(x_q)};
			OPR_LEQ: alu = {31'd0, !($signed(y_q) < $signed(x_q))};
			default: alu = x_q;
		endcase
	end

	assign lev_eff = (32'(in_data.level) > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(in_data.level);
	assign stopped_n = stopped_q | (pc_q == 11'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= '0;
			b_q       <= AW'(1);
			t_q       <= '0;
			stopped_q <= 1'b0;
			clr_cnt_q <= '0;
			rd_pend_q <= 1'b0;
			out_vld_q <= 1'b0;
			md_cnt_q  <= '0;
		end else begin
			if (cmd.clr_en) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			rd_pend_q <= cmd.rd_en;
			if (md_start) begin
				md_cnt_q <= 2'd2;
			end else if (md_cnt_q != '0) begin
				md_cnt_q <= md_cnt_q - 2'd1;
			end
			if (cmd.accept && !stopped_q) begin
				pc_q <= pc_q + 11'd1;
			end
			case (cmd.pc_op)
				PC_A:    pc_q <= a_q;
				PC_X:    pc_q <= x_q[10:0];
				PC_AIFZ: if (x_q == '0) pc_q <= a_q;
				default: ;
			endcase
			case (cmd.t_op)
				T_INC:   t_q <= t_inc;
				T_DEC:   t_q <= t_dec;
				T_BDEC:  t_q <= b_dec;
				T_REM:   t_q <= md_rem[AW-1:0];
				default: ;
			endcase
			case (cmd.b_op)
				B_TINC:  b_q <= t_inc;
				B_REM:   b_q <= md_rem[AW-1:0];
				default: ;
			endcase
			if (cmd.out_load) begin
				stopped_q <= stopped_n;
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q      <= in_data.operation;
			a_q       <= in_data.operand;
			rv_q      <= in_data.read_value;
			lev_cnt_q <= lev_eff;
			rng_err_q <= 1'b0;
			div_err_q <= 1'b0;
			wv_q      <= 1'b0;
		end
		if ((cmd.rd_en || cmd.wr_en) && !in_range) begin
			rng_err_q <= 1'b1;
		end
		rd_ok_q  <= in_range;
		rd_dst_q <= cmd.dst;
		if (rd_pend_q) begin
			case (rd_dst_q)
				DST_X:    x_q    <= rd_val;
				DST_Y:    y_q    <= rd_val;
				DST_BASE: base_q <= rd_val;
				default:  x_q    <= rd_val;
			endcase
		end
		if (cmd.walk_init) begin
			base_q <= 32'(b_q);
		end
		if (cmd.walk_dec) begin
			lev_cnt_q <= lev_cnt_q - LW'(1);
		end
		if (md_start) begin
			md_src_q <= (cmd.dmode == DM_MODY) ? y_q : 32'(t_q) + 32'(a_q);
		end
		md_prod_q <= {32'd0, md_src_q} * {32'd0, RECIP};
		md_est_q  <= md_src_q - md_prod_q[63:32] * DEPTH32;
		if (cmd.alu_en) begin
			res_q <= alu;
			if (a_q == OPR_DIV && y_q == '0) begin
				div_err_q <= 1'b1;
			end
		end
		if (cmd.wrt_en) begin
			wv_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_q.next_pc   <= pc_q;
			out_q.halted    <= stopped_n;
			out_q.out_valid <= wv_q;
			out_q.out_value <= wv_q ? x_q : '0;
			out_q.status    <= rng_err_q ? STAT_RANGE : (div_err_q ? STAT_DIV0 : STAT_OK);
		end
	end

	always_comb begin
		sts.clr_last   = clr_cnt_q == TOP_IDX;
		sts.stopped    = stopped_q;
		sts.op         = op_q;
		sts.opr_ret    = a_q == OPR_RET;
		sts.opr_unary  = (a_q == OPR_NEG) || (a_q == OPR_ODD);
		sts.opr_binary = ((a_q >= OPR_ADD) && (a_q <= OPR_DIV)) ||
		                 ((a_q >= OPR_EQL) && (a_q <= OPR_LEQ));
		sts.opr_div    = a_q == OPR_DIV;
		sts.y_zero     = y_q == '0;
		sts.lev_zero   = lev_cnt_q == '0;
		sts.div_busy   = dv_busy || (md_cnt_q != '0);
		sts.out_free   = !out_vld_q || out_ready;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(t_q) < STACK_DEPTH) else $error("stack top out of range");
	a_b_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(b_q) < STACK_DEPTH) else $error("frame base out of range");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q) else $error("halt cleared");
	a_stop_pc: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> pc_q == 11'd0) else $error("pc moved after halt");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_vld_q) else $error("result not presented");
`endif
endmodule

// ===== rtl/pl0sm_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0sm_controller
// Sequencer: clears the stack after reset and steps each instruction through
// reads, ALU, divider and writes of the datapath.
// ----------------------------------------------------------------------------
module pl0sm_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pl0sm_pkg::sts_t sts,
	output pl0sm_pkg::cmd_t cmd
);
	import pl0sm_pkg::*;

	typedef enum logic [28:0] {
		S_CLEAR     = 29'd1 << 0,
		S_IDLE      = 29'd1 << 1,
		S_DECODE    = 29'd1 << 2,
		S_LIT_WR    = 29'd1 << 3,
		S_RET_RD3   = 29'd1 << 4,
		S_RET_RD2   = 29'd1 << 5,
		S_RET_WAIT  = 29'd1 << 6,
		S_RET_SET   = 29'd1 << 7,
		S_MODB_WAIT = 29'd1 << 8,
		S_MODT_WAIT = 29'd1 << 9,
		S_UN_WAIT   = 29'd1 << 10,
		S_UN_ALU    = 29'd1 << 11,
		S_BIN_RDX   = 29'd1 << 12,
		S_BIN_RDY   = 29'd1 << 13,
		S_BIN_WAIT  = 29'd1 << 14,
		S_BIN_EXEC  = 29'd1 << 15,
		S_DIV_WAIT  = 29'd1 << 16,
		S_WR_RES    = 29'd1 << 17,
		S_WALK      = 29'd1 << 18,
		S_WALK_WAIT = 29'd1 << 19,
		S_LOD_WAIT  = 29'd1 << 20,
		S_LOD_WR    = 29'd1 << 21,
		S_STO_WAIT  = 29'd1 << 22,
		S_STO_WR    = 29'd1 << 23,
		S_CAL2      = 29'd1 << 24,
		S_CAL3      = 29'd1 << 25,
		S_TOP_WAIT  = 29'd1 << 26,
		S_TOP_DO    = 29'd1 << 27,
		S_FINISH    = 29'd1 << 28
	} state_t;

	state_t state_q;
	state_t state_n;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = S_DECODE;
				end
			end
			S_DECODE: begin
				state_n = S_FINISH;
				if (!sts.stopped) begin
					case (sts.op)
						OP_LIT: begin
							cmd.t_op = T_INC;
							state_n  = S_LIT_WR;
						end
						OP_OPR: begin
							if (sts.opr_ret) begin
								cmd.t_op = T_BDEC;
								state_n  = S_RET_RD3;
							end else if (sts.opr_unary) begin
								cmd.rd_en = 1'b1;
								cmd.asel  = AS_T;
								cmd.dst   = DST_X;
								state_n   = S_UN_WAIT;
							end else if (sts.opr_binary) begin
								cmd.t_op = T_DEC;
								state_n  = S_BIN_RDX;
							end
						end
						OP_LOD, OP_STO, OP_CAL, OP_RED: begin
							cmd.walk_init = 1'b1;
							state_n       = S_WALK;
						end
						OP_INT: begin
							cmd.div_start = 1'b1;
							cmd.dmode     = DM_MODTA;
							state_n       = S_MODT_WAIT;
						end
						OP_JMP: cmd.pc_op = PC_A;
						OP_JPC, OP_WRT: begin
							cmd.rd_en = 1'b1;
							cmd.asel  = AS_T;
							cmd.dst   = DST_X;
							state_n   = S_TOP_WAIT;
						end
						default: ;
					endcase
				end
			end
			S_LIT_WR: begin
				cmd.wr_en = 1'b1;
				cmd.asel  = AS_T;
				cmd.wsel  = WD_A;
				state_n   = S_FINISH;
			end
			S_RET_RD3: begin
				cmd.rd_en = 1'b1;
				cmd.asel  = AS_T_P3;
				cmd.dst   = DST_X;
				state_n   = S_RET_RD2;
			end
			S_RET_RD2: begin
				cmd.rd_en = 1'b1;
				cmd.asel  = AS_T_P2;
				cmd.dst   = DST_Y;
				state_n   = S_RET_WAIT;
			end
			S_RET_WAIT: state_n = S_RET_SET;
			S_RET_SET: begin
				cmd.pc_op     = PC_X;
				cmd.div_start = 1'b1;
				cmd.dmode     = DM_MODY;
				state_n       = S_MODB_WAIT;
			end
			S_MODB_WAIT: begin
				if (!sts.div_busy) begin
					cmd.b_op = B_REM;
					state_n  = S_FINISH;
				end
			end
			S_MODT_WAIT: begin
				if (!sts.div_busy) begin
					cmd.t_op = T_REM;
					state_n  = S_FINISH;
				end
			end
			S_UN_WAIT: state_n = S_UN_ALU;
			S_UN_ALU: begin
				cmd.alu_en = 1'b1;
				state_n    = S_WR_RES;
			end
			S_BIN_RDX: begin
				cmd.rd_en = 1'b1;
				cmd.asel  = AS_T;
				cmd.dst   = DST_X;
				state_n   = S_BIN_RDY;
			end
			S_BIN_RDY: begin
				cmd.rd_en = 1'b1;
				cmd.asel  = AS_T_P1;
				cmd.dst   = DST_Y;
				state_n   = S_BIN_WAIT;
			end
			S_BIN_WAIT: state_n = S_BIN_EXEC;
			S_BIN_EXEC: begin
				if (sts.opr_div && !sts.y_zero) begin
					cmd.div_start = 1'b1;
					cmd.dmode     = DM_DIV;
					state_n       = S_DIV_WAIT;
				end else begin
					cmd.alu_en = 1'b1;
					state_n    = S_WR_RES;
				end
			end
			S_DIV_WAIT: begin
				if (!sts.div_busy) begin
					cmd.alu_en = 1'b1;
					state_n    = S_WR_RES;
				end
			end
			S_WR_RES: begin
				cmd.wr_en = 1'b1;
				cmd.asel  = AS_T;
				cmd.wsel  = WD_RES;
				state_n   = S_FINISH;
			end
			S_WALK: begin
				if (!sts.lev_zero) begin
					cmd.rd_en    = 1'b1;
					cmd.asel     = AS_BASE;
					cmd.dst      = DST_BASE;
					cmd.walk_dec = 1'b1;
					state_n      = S_WALK_WAIT;
				end else begin
					case (sts.op)
						OP_LOD: begin
							cmd.rd_en = 1'b1;
							cmd.asel  = AS_BASE_A;
							cmd.dst   = DST_X;
							state_n   = S_LOD_WAIT;
						end
						OP_STO: begin
							cmd.rd_en = 1'b1;
							cmd.asel  = AS_T;
							cmd.dst   = DST_X;
							state_n   = S_STO_WAIT;
						end
						OP_CAL: begin
							cmd.wr_en = 1'b1;
							cmd.asel  = AS_T_P1;
							cmd.wsel  = WD_BASE;
							state_n   = S_CAL2;
						end
						OP_RED: begin
							cmd.wr_en = 1'b1;
							cmd.asel  = AS_BASE_A;
							cmd.wsel  = WD_RV;
							state_n   = S_FINISH;
						end
						default: state_n = S_FINISH;
					endcase
				end
			end
			S_WALK_WAIT: state_n = S_WALK;
			S_LOD_WAIT: begin
				cmd.t_op = T_INC;
				state_n  = S_LOD_WR;
			end
			S_LOD_WR: begin
				cmd.wr_en = 1'b1;
				cmd.asel  = AS_T;
				cmd.wsel  = WD_X;
				state_n   = S_FINISH;
			end
			S_STO_WAIT: state_n = S_STO_WR;
			S_STO_WR: begin
				cmd.wr_en = 1'b1;
				cmd.asel  = AS_BASE_A;
				cmd.wsel  = WD_X;
				cmd.t_op  = T_DEC;
				state_n   = S_FINISH;
			end
			S_CAL2: begin
				cmd.wr_en = 1'b1;
				cmd.asel  = AS_T_P2;
				cmd.wsel  = WD_B;
				state_n   = S_CAL3;
			end
			S_CAL3: begin
				// return address is the already advanced pc
				cmd.wr_en = 1'b1;
				cmd.asel  = AS_T_P3;
				cmd.wsel  = WD_PC;
				cmd.b_op  = B_TINC;
				cmd.pc_op = PC_A;
				state_n   = S_FINISH;
			end
			S_TOP_WAIT: state_n = S_TOP_DO;
			S_TOP_DO: begin
				if (sts.op == OP_JPC) cmd.pc_op = PC_AIFZ;
				else cmd.wrt_en = 1'b1;
				cmd.t_op = T_DEC;
				state_n  = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PL/0 p-code stack machine. A directed program
// walks the instruction set and its corner cases. A random program follows,
// mostly well-formed call frames plus loose instructions. An in-bench copy of
// the machine predicts every result. Idling runs in four phases, and there is
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	import pl0sm_pkg::*;

	localparam int DEPTH   = 512;
	localparam int N_RAND  = 600;
	localparam int N_ERR   = 10;
	localparam logic [3:0]  OP_SPARE  = 4'd15;
	localparam logic [10:0] OPR_SPARE = 11'd7;
	localparam logic [10:0] OPR_TOP   = 11'd2047;
	localparam logic [31:0] MIN_INT   = 32'h8000_0000;

	typedef struct {
		logic [31:0] stk [DEPTH];
		logic [10:0] pc;
		logic [8:0]  base;
		logic [8:0]  top;
		bit          stop;
	} mach_t;

	typedef struct {
		in_item_t    req;
		out_item_t   res;
		int unsigned phase;
	} pend_t;

	int unsigned tx_idle [4] = '{0, 63, 0, 38};
	int unsigned rx_idle [4] = '{0, 0, 63, 38};

	logic clk;
	logic arst_n;
	pl0sm_in_if  instr_if ();
	pl0sm_out_if res_if ();

	pl0_pcode_stack_machine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_if),
		.result (res_if)
	);

	mach_t       mach;
	pend_t       instr_q [$];
	pend_t       result_q [$];
	int unsigned cur_phase;
	int unsigned n_err;
	int unsigned n_results;
	bit          hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [31:0] stk_rd(ref mach_t m, input longint unsigned idx,
		ref bit rerr);
		if (idx >= DEPTH) begin
			rerr = 1'b1;
			return 32'd0;
		end
		return m.stk[idx];
	endfunction

	function automatic void stk_wr(ref mach_t m, input longint unsigned idx,
		input logic [31:0] v, ref bit rerr);
		if (idx >= DEPTH)
			rerr = 1'b1;
		else
			m.stk[idx] = v;
	endfunction

	function automatic longint unsigned frame_of(ref mach_t m, input logic [1:0] lev,
		ref bit rerr);
		longint unsigned b1;
		b1 = m.base;
		repeat (lev) b1 = stk_rd(m, b1, rerr);
		return b1;
	endfunction

	// advance the machine by one instruction
	function automatic out_item_t execute(ref mach_t m, input in_item_t it);
		out_item_t r;
		bit rerr, derr;
		logic [31:0] x, y, v;
		logic [8:0] t;
		longint unsigned fb;
		r = '0;
		if (m.stop) begin
			r.halted = 1'b1;
			return r;
		end
		rerr = 0;
		derr = 0;
		m.pc = m.pc + 11'd1;
		t = m.top;
		case (it.operation)
			OP_LIT: begin
				m.top = t + 9'd1;
				stk_wr(m, m.top, {21'd0, it.operand}, rerr);
			end
			OP_OPR: begin
				if (it.operand == OPR_RET) begin
					m.top = m.base - 9'd1;
					m.pc = 11'(stk_rd(m, longint'(m.top) + 3, rerr));
					m.base = 9'(stk_rd(m, longint'(m.top) + 2, rerr) % DEPTH);
				end else if (it.operand == OPR_NEG) begin
					stk_wr(m, t, -stk_rd(m, t, rerr), rerr);
				end else if (it.operand == OPR_ODD) begin
					stk_wr(m, t, stk_rd(m, t, rerr) & 32'd1, rerr);
				end else if ((it.operand >= OPR_ADD && it.operand <= OPR_DIV) ||
					(it.operand >= OPR_EQL && it.operand <= OPR_LEQ)) begin
					m.top = t - 9'd1;
					x = stk_rd(m, m.top, rerr);
					y = stk_rd(m, longint'(m.top) + 1, rerr);
					case (it.operand)
						OPR_ADD: v = x + y;
						OPR_SUB: v = x - y;
						OPR_MUL: v = x * y;
						OPR_DIV: begin
							if (y == 0) begin
								derr = 1;
								v = 0;
							end else if (x == MIN_INT && y == '1) begin
								v = MIN_INT;
							end else begin
								v = $signed(x) / $signed(y);
							end
						end
						OPR_EQL: v = {31'd0, x == y};
						OPR_NEQ: v = {31'd0, x != y};
						OPR_LSS: v = {31'd0, $signed(x) < $signed(y)};
						OPR_GEQ: v = {31'd0, $signed(x) >= $signed(y)};
						OPR_GTR: v = {31'd0, $signed(x) > $signed(y)};
						default: v = {31'd0, $signed(x) <= $signed(y)};
					endcase
					stk_wr(m, m.top, v, rerr);
				end
			end
			OP_LOD: begin
				fb = frame_of(m, it.level, rerr);
				x = stk_rd(m, fb + it.operand, rerr);
				m.top = t + 9'd1;
				stk_wr(m, m.top, x, rerr);
			end
			OP_STO: begin
				fb = frame_of(m, it.level, rerr);
				stk_wr(m, fb + it.operand, stk_rd(m, t, rerr), rerr);
				m.top = t - 9'd1;
			end
			OP_CAL: begin
				fb = frame_of(m, it.level, rerr);
				stk_wr(m, longint'(t) + 1, fb[31:0], rerr);
				stk_wr(m, longint'(t) + 2, {23'd0, m.base}, rerr);
				stk_wr(m, longint'(t) + 3, {21'd0, m.pc}, rerr);
				m.base = t + 9'd1;
				m.pc = it.operand;
			end
			OP_INT: m.top = t + it.operand[8:0];
			OP_JMP: m.pc = it.operand;
			OP_JPC: begin
				if (stk_rd(m, t, rerr) == 0) m.pc = it.operand;
				m.top = t - 9'd1;
			end
			OP_RED: begin
				fb = frame_of(m, it.level, rerr);
				stk_wr(m, fb + it.operand, it.read_value, rerr);
			end
			OP_WRT: begin
				r.out_value = stk_rd(m, t, rerr);
				r.out_valid = 1'b1;
				m.top = t - 9'd1;
			end
			default: ;
		endcase
		if (m.pc == 0) m.stop = 1;
		r.next_pc = m.pc;
		r.halted = m.stop;
		r.status = rerr ? STAT_RANGE : (derr ? STAT_DIV0 : STAT_OK);
		return r;
	endfunction

	function automatic in_item_t mk(logic [3:0] op, logic [1:0] lev, logic [10:0] a,
		logic [31:0] rv = 32'd0);
		in_item_t it;
		it.operation = op;
		it.level = lev;
		it.operand = a;
		it.read_value = rv;
		return it;
	endfunction

	// run the item through the model; unless a halt is wanted, reroute
	// anything that would stop the machine into a nonzero jump
	task automatic issue(in_item_t it, bit may_halt = 0, int unsigned ph = 0);
		mach_t trial;
		pend_t p;
		trial = mach;
		p.res = execute(trial, it);
		if (!may_halt && trial.stop) begin
			it = mk(OP_JMP, 2'($urandom), 11'($urandom_range(1, 2047)), $urandom);
			trial = mach;
			p.res = execute(trial, it);
		end
		mach = trial;
		p.req = it;
		p.phase = ph;
		instr_q.push_back(p);
	endtask

	function automatic in_item_t rand_instr();
		int unsigned w;
		logic [10:0] a;
		logic [1:0] lev;
		w = $urandom_range(99);
		lev = 2'($urandom);
		a = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 12));
		if (w < 18) return mk(OP_LIT, lev, 11'($urandom), $urandom);
		if (w < 44) begin
			if ($urandom_range(19) == 0) return mk(OP_OPR, lev, 11'($urandom), $urandom);
			return mk(OP_OPR, lev, 11'($urandom_range(1, 13)), $urandom);
		end
		if (w < 56) return mk(OP_LOD, lev, a, $urandom);
		if (w < 65) return mk(OP_STO, lev, a, $urandom);
		if (w < 73) return mk(OP_RED, lev, a, $urandom);
		if (w < 81) return mk(OP_WRT, lev, a, $urandom);
		if (w < 86) return mk(OP_JPC, lev, 11'($urandom), $urandom);
		if (w < 89) return mk(OP_JMP, lev, 11'($urandom), $urandom);
		if (w < 93) begin
			if ($urandom_range(7) == 0) return mk(OP_INT, lev, 11'($urandom), $urandom);
			return mk(OP_INT, lev, 11'($urandom_range(0, 6)), $urandom);
		end
		if (w < 95) return mk(OP_CAL, lev, 11'($urandom), $urandom);
		if (w < 97) return mk(OP_OPR, lev, OPR_RET, $urandom);
		return mk(4'($urandom_range(10, 15)), lev, 11'($urandom), $urandom);
	endfunction

	// a procedure call with a small body and a return
	task automatic call_frame(int unsigned ph);
		int unsigned n;
		issue(mk(OP_CAL, 2'($urandom), 11'($urandom_range(1, 2047)), $urandom), 0, ph);
		issue(mk(OP_INT, 2'($urandom), 11'($urandom_range(3, 7)), $urandom), 0, ph);
		n = $urandom_range(1, 6);
		repeat (n) issue(rand_instr(), 0, ph);
		issue(mk(OP_LOD, 2'($urandom_range(0, 3)), 11'($urandom_range(0, 4)), $urandom),
			0, ph);
		issue(mk(OP_WRT, 2'($urandom), 11'($urandom), $urandom), 0, ph);
		issue(mk(OP_OPR, 2'($urandom), OPR_RET, $urandom), 0, ph);
	endtask

	initial begin
		int unsigned cnt, ph;
		mach.stk = '{default: 32'd0};
		mach.pc = 0;
		mach.base = 9'd1;
		mach.top = 0;
		mach.stop = 0;
		// directed
		issue(mk(OP_INT, 0, 11'd8));
		issue(mk(OP_LIT, 0, 11'd0));
		issue(mk(OP_LIT, 0, 11'd2047));
		issue(mk(OP_OPR, 0, OPR_NEG));
		issue(mk(OP_OPR, 0, OPR_ADD));
		issue(mk(OP_RED, 0, 11'd5, MIN_INT));
		issue(mk(OP_RED, 0, 11'd6, 32'hffff_ffff));
		issue(mk(OP_LOD, 0, 11'd5));
		issue(mk(OP_LOD, 0, 11'd6));
		issue(mk(OP_OPR, 0, OPR_DIV));        // most negative / -1
		issue(mk(OP_LIT, 0, 11'd0));
		issue(mk(OP_OPR, 0, OPR_DIV));        // divide by zero
		issue(mk(OP_OPR, 0, OPR_ODD));
		issue(mk(OP_LOD, 2'd3, 11'd2047));    // deep walk, index out of range
		issue(mk(OP_STO, 0, 11'd1));
		issue(mk(OP_CAL, 2'd3, 11'd100));
		issue(mk(OP_INT, 0, 11'd3));
		issue(mk(OP_OPR, 0, OPR_RET));
		issue(mk(OP_LIT, 0, 11'd0));
		issue(mk(OP_JPC, 0, 11'd50));         // taken
		issue(mk(OP_LIT, 0, 11'd1));
		issue(mk(OP_JPC, 0, 11'd60));         // not taken
		issue(mk(OP_JMP, 0, 11'd2047));
		issue(mk(OP_OPR, 0, OPR_SPARE));
		issue(mk(OP_OPR, 0, OPR_TOP));
		issue(mk(OP_SPARE, 2'd3, 11'd2047, 32'hffff_ffff));
		issue(mk(OP_WRT, 0, 11'd0));
		issue(mk(OP_INT, 0, 11'd2047));       // top wraps
		// random, in four idling phases
		cnt = 0;
		while (cnt < N_RAND) begin
			ph = cnt * 4 / N_RAND;
			if ($urandom_range(99) < 60) begin
				call_frame(ph);
				cnt += 9;
			end else begin
				issue(rand_instr(), 0, ph);
				cnt++;
			end
		end
		issue(mk(OP_JMP, 0, 11'd0), 1, 3);
		repeat (3) issue(rand_instr(), 1, 3);

		do @(posedge clk); while (instr_q.size() != 0 || result_q.size() != 0);
		repeat (100) @(posedge clk);
		if (n_err == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: done, errors");
		$finish;
	end

	// long receiver hold-off while requests keep coming
	initial begin
		hold = 1'b0;
		wait (n_results == 120);
		@(posedge clk);
		hold <= 1'b1;
		repeat (400) @(posedge clk);
		hold <= 1'b0;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			instr_if.valid <= 1'b0;
			instr_if.data <= '0;
		end else begin
			go = 0;
			if (instr_if.valid && instr_if.ready) begin
				result_q.push_back(instr_q.pop_front());
			end
			if (!instr_if.valid || instr_if.ready) begin
				if (instr_q.size() != 0 &&
					$urandom_range(99) >= tx_idle[instr_q[0].phase]) begin
					go = 1;
					instr_if.data <= instr_q[0].req;
				end
				instr_if.valid <= go;
			end
		end
	end

	task automatic check_result(out_item_t got);
		pend_t e;
		bit bad;
		if (result_q.size() == 0) begin
			n_err++;
			if (n_err <= N_ERR) $display("tb: result with nothing pending: %p", got);
			return;
		end
		e = result_q.pop_front();
		cur_phase = e.phase;
		bad = got.next_pc != e.res.next_pc || got.halted != e.res.halted ||
			got.out_valid != e.res.out_valid || got.out_value != e.res.out_value ||
			got.status != e.res.status;
		if (bad) begin
			n_err++;
			if (n_err <= N_ERR) begin
				$write("tb: mismatch op %0d a %0d: exp pc %0d h %0b v %0b %0d st %0d,",
					e.req.operation, e.req.operand, e.res.next_pc, e.res.halted,
					e.res.out_valid, e.res.out_value, e.res.status);
				$display(" got pc %0d h %0b v %0b %0d st %0d", got.next_pc,
					got.halted, got.out_valid, got.out_value, got.status);
			end
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			n_err = 0;
			n_results = 0;
			cur_phase = 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				check_result(res_if.data);
				n_results++;
			end
			res_if.ready <= !hold && $urandom_range(99) >= rx_idle[cur_phase];
		end
	end

endmodule
